### rtl/core/note_repeat_sample_player_assert.svh
// Assertion macros shared by the sample player modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef NOTE_REPEAT_SAMPLE_PLAYER_ASSERT_SVH
`define NOTE_REPEAT_SAMPLE_PLAYER_ASSERT_SVH

`ifndef SYNTHESIS
`define NRSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define NRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NRSP_ASSERT_ALWAYS(lbl, cond, msg)
`define NRSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/nrsp_pkg.sv
// Types, codes and constants of the note repeat sample player.
// No dependencies; imported by every module of the block but the RAM.
package nrsp_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int POS_W        = ADDR_W + 1;

    localparam int NOTE_W   = 7;
    localparam int WADDR_W  = 16;
    localparam int SPB_W    = 21;
    localparam int LEN_W    = 17;
    localparam int VOL_W    = 7;
    localparam int TIMER_W  = SPB_W;

    localparam int TEMPO_N     = 12;
    localparam int TEMPO_IDX_W = $clog2(TEMPO_N);
    localparam logic [NOTE_W-1:0] TEMPO_LOW  = 7'd60;
    localparam logic [NOTE_W-1:0] TEMPO_HIGH = 7'd71;
    localparam int DIV_W = 8;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Volume scaling: x * vol / 100 by reciprocal multiply, exact over the product range
    localparam int VOL_SCALE = 100;
    localparam int DIV_SHIFT = SAMPLE_BITS + 14;
    localparam int PROD_W    = SAMPLE_BITS + VOL_W + 1;
    localparam int MAG_W     = PROD_W - 1;
    localparam int RECIP_W   = SAMPLE_BITS + 8;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(VOL_SCALE) - 64'd1) / 64'(VOL_SCALE));
    localparam int MK_W = MAG_W + RECIP_W;
    localparam int Q_W  = MK_W - DIV_SHIFT;
    localparam logic [Q_W-1:0] Q_POS_LIM = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_NEG_LIM = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [1:0] ACT_NOTE_ON   = 2'd0;
    localparam logic [1:0] ACT_NOTE_OFF  = 2'd1;
    localparam logic [1:0] ACT_TICK      = 2'd2;
    localparam logic [1:0] ACT_MEM_WRITE = 2'd3;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_WRITE    = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_SPB    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MONO   = 2'd3;

    localparam logic [SPB_W-1:0] SPB_RESET    = 21'd22154;
    localparam logic [LEN_W-1:0] LENGTH_RESET = '0;
    localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd100;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = t_sample'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam t_sample SAMPLE_MIN = t_sample'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    typedef struct packed {
        logic [1:0]         action;
        logic [NOTE_W-1:0]  note;
        logic [WADDR_W-1:0] write_address;
        t_sample            write_left;
        t_sample            write_right;
    } t_in_item;

    typedef struct packed {
        t_sample out_left;
        t_sample out_right;
        logic    playing;
    } t_out_item;

    typedef struct packed {
        logic [SPB_W-1:0] samples_per_beat;
        logic [LEN_W-1:0] sample_length;
        logic [VOL_W-1:0] volume_percent;
        logic             mono_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]             kind;
        logic [TEMPO_IDX_W-1:0] tempo_idx;
        logic [ADDR_W-1:0]      waddr;
        t_sample                left;
        t_sample                right;
    } t_op;

    function automatic logic [DIV_W-1:0] tempo_div(input logic [TEMPO_IDX_W-1:0] idx);
        logic [DIV_W-1:0] d;
        unique case (idx)
            4'd0:    d = 8'd2;
            4'd1:    d = 8'd3;
            4'd2:    d = 8'd4;
            4'd3:    d = 8'd6;
            4'd4:    d = 8'd8;
            4'd5:    d = 8'd16;
            4'd6:    d = 8'd12;
            4'd7:    d = 8'd32;
            4'd8:    d = 8'd24;
            4'd9:    d = 8'd64;
            4'd10:   d = 8'd48;
            4'd11:   d = 8'd128;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/note_repeat_sample_player.sv
// Note repeat sample player, top level: APB register file, front end and back end.
// Depends on nrsp_pkg, nrsp_front and nrsp_back.
//
// Takes one input beat per clock unless the four-entry command queue is full, and returns
// one result beat per audio tick; note and memory-write beats give no result. A tick's
// result reaches the output register through registered steps after the queue: the
// sample memory read, the volume multiply, the reciprocal divide by 100 and the saturating
// output stage. A stalled output holds the back pipeline while the queue keeps taking
// input until it fills. Sample memory has no reset and no clearing pass, so the block
// accepts input right after reset; frames must be written before they are played.
// The user must write registers through APB only while the block is idle; the block
// itself does not enforce this.

module note_repeat_sample_player import nrsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                 r_cfg;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 op_valid;
    t_op                  op;
    logic                 pop;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_beat <= SPB_RESET;
            r_cfg.sample_length    <= LENGTH_RESET;
            r_cfg.volume_percent   <= VOLUME_RESET;
            r_cfg.mono_mode        <= 1'b0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_SPB:    r_cfg.samples_per_beat <= pwdata[SPB_W-1:0];
                REG_LENGTH: r_cfg.sample_length    <= pwdata[LEN_W-1:0];
                REG_VOLUME: r_cfg.volume_percent   <= pwdata[VOL_W-1:0];
                REG_MONO:   r_cfg.mono_mode        <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SPB:    prdata = APB_DATA_W'(r_cfg.samples_per_beat);
            REG_LENGTH: prdata = APB_DATA_W'(r_cfg.sample_length);
            REG_VOLUME: prdata = APB_DATA_W'(r_cfg.volume_percent);
            REG_MONO:   prdata = APB_DATA_W'(r_cfg.mono_mode);
        endcase
    end

    nrsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_pop      (pop)
    );

    nrsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

### rtl/core/nrsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nrsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/nrsp_front.sv
// Front end: accepts input beats, classifies them and queues the ones that matter.
// Depends on nrsp_pkg and the assertion macro header.
`include "note_repeat_sample_player_assert.svh"

module nrsp_front import nrsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    output logic     o_op_valid,
    output t_op      o_op,
    input  logic     i_pop
);

    t_op               r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    t_op  op_c;
    logic keep_c;
    logic is_tempo_c;
    logic push_c;

    always_comb begin
        is_tempo_c   = (i_in_item.note >= TEMPO_LOW) && (i_in_item.note <= TEMPO_HIGH);
        op_c.kind      = OP_TICK;
        op_c.tempo_idx = TEMPO_IDX_W'(i_in_item.note - TEMPO_LOW);
        op_c.waddr     = ADDR_W'(i_in_item.write_address);
        op_c.left      = i_in_item.write_left;
        op_c.right     = i_in_item.write_right;
        keep_c         = 1'b1;
        unique case (i_in_item.action)
            ACT_NOTE_ON: begin
                op_c.kind = OP_NOTE_ON;
                keep_c    = is_tempo_c;
            end
            ACT_NOTE_OFF: begin
                op_c.kind = OP_NOTE_OFF;
                keep_c    = is_tempo_c;
            end
            ACT_TICK: begin
                op_c.kind = OP_TICK;
            end
            ACT_MEM_WRITE: begin
                op_c.kind = OP_WRITE;
                keep_c    = 32'(i_in_item.write_address) < 32'(SAMPLE_DEPTH);
            end
        endcase
    end

    assign o_in_stall = (r_count == QCNT_W'(Q_DEPTH));
    assign push_c     = i_in_valid && !o_in_stall && keep_c;
    assign n_count    = r_count + QCNT_W'(push_c) - QCNT_W'(i_pop);
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_c) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_c) begin
            r_q[r_wr_ptr] <= op_c;
        end
    end

    `NRSP_ASSERT_ALWAYS(a_no_pop_empty, !(i_pop && r_count == '0), "pop from empty queue")
    `NRSP_ASSERT_ALWAYS(a_count_bound, r_count <= QCNT_W'(Q_DEPTH), "queue count overflow")

endmodule

### rtl/core/nrsp_back.sv
// Back end: note map, beat timer, playback position, sample memory and gain pipeline.
// Depends on nrsp_pkg, nrsp_ram and the assertion macro header.
`include "note_repeat_sample_player_assert.svh"

module nrsp_back import nrsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_op_valid,
    input  t_op       i_op,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic [TEMPO_N-1:0] r_held;
    logic [TEMPO_N-1:0] n_held;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [TIMER_W-1:0] r_timer;
    logic [TIMER_W-1:0] n_timer;

    logic                       advance;
    logic                       take;
    logic                       play_c;
    logic                       restart_c;
    logic                       emit_c;
    logic                       tick_c;
    logic [DIV_W-1:0]           div_c;
    logic [TIMER_W+DIV_W-1:0]   span_c;
    logic [POS_W-1:0]           len_c;
    logic [POS_W-1:0]           pos_eff;
    logic [TIMER_W-1:0]         timer_eff;
    logic                       ram_we;
    logic [2*SAMPLE_BITS-1:0]   ram_rdata;

    logic                       r_b_valid;
    logic                       r_b_play;
    logic                       r_b_emit;
    logic                       r_c_valid;
    logic                       r_c_play;
    logic signed [PROD_W-1:0]   r_c_prod_l;
    logic signed [PROD_W-1:0]   r_c_prod_r;
    logic                       r_d_valid;
    logic                       r_d_play;
    logic [MK_W-1:0]            r_d_mk_l;
    logic [MK_W-1:0]            r_d_mk_r;
    logic                       r_d_neg_l;
    logic                       r_d_neg_r;
    logic                       r_out_valid;
    t_out_item                  r_out_item;

    t_sample                    data_l;
    t_sample                    data_r;
    logic signed [PROD_W-1:0]   vol_s;
    logic [MAG_W-1:0]           mag_l;
    logic [MAG_W-1:0]           mag_r;

    function automatic t_sample sat_scale(input logic [MK_W-1:0] mk, input logic neg);
        logic [Q_W-1:0] q;
        logic [Q_W-1:0] nq;
        t_sample        res;
        q  = mk[MK_W-1:DIV_SHIFT];
        nq = Q_W'(0) - q;
        if (!neg) begin
            res = (q > Q_POS_LIM) ? SAMPLE_MAX : t_sample'(q[SAMPLE_BITS-1:0]);
        end else begin
            res = (q > Q_NEG_LIM) ? SAMPLE_MIN : t_sample'(nq[SAMPLE_BITS-1:0]);
        end
        return res;
    endfunction

    assign advance = !r_out_valid || !i_out_stall;
    assign take    = advance && i_op_valid;
    assign o_pop   = take;

    // Tick decision: tempo divider, beat restart, position gate; note-on/off and memory-write updates
    always_comb begin
        play_c = 1'b0;
        div_c  = DIV_W'(1);
        for (int i = 0; i < TEMPO_N; i++) begin
            if (r_held[i]) begin
                play_c = 1'b1;
                div_c  = tempo_div(TEMPO_IDX_W'(i));
            end
        end
        span_c    = (TIMER_W+DIV_W)'(r_timer) * (TIMER_W+DIV_W)'(div_c);
        restart_c = span_c >= (TIMER_W+DIV_W)'(i_cfg.samples_per_beat);
        if (32'(i_cfg.sample_length) > 32'(SAMPLE_DEPTH)) begin
            len_c = POS_W'(SAMPLE_DEPTH);
        end else begin
            len_c = POS_W'(i_cfg.sample_length);
        end
        pos_eff   = restart_c ? '0 : r_pos;
        timer_eff = restart_c ? '0 : r_timer;
        emit_c    = play_c && (pos_eff < len_c);
        tick_c    = take && (i_op.kind == OP_TICK);

        n_held  = r_held;
        n_pos   = r_pos;
        n_timer = r_timer;
        ram_we  = 1'b0;
        if (take) begin
            unique case (i_op.kind)
                OP_NOTE_ON: begin
                    n_held[i_op.tempo_idx] = 1'b1;
                    n_pos                  = '0;
                    n_timer                = '0;
                end
                OP_NOTE_OFF: begin
                    n_held[i_op.tempo_idx] = 1'b0;
                end
                OP_TICK: begin
                    n_pos   = emit_c ? pos_eff + 1'b1 : pos_eff;
                    n_timer = (timer_eff == TIMER_MAX) ? timer_eff : timer_eff + 1'b1;
                end
                OP_WRITE: begin
                    ram_we = 1'b1;
                end
            endcase
        end
    end

    nrsp_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_op.waddr),
        .i_wdata ({i_op.left, i_op.right}),
        .i_re    (advance),
        .i_raddr (pos_eff[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Gain: gate samples (silence, mono), multiply by volume, then divide by 100 via reciprocal
    always_comb begin
        data_l = r_b_emit ? t_sample'(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
        data_r = (r_b_emit && !i_cfg.mono_mode) ? t_sample'(ram_rdata[SAMPLE_BITS-1:0]) : '0;
        vol_s  = PROD_W'($signed({1'b0, i_cfg.volume_percent}));
        mag_l  = r_c_prod_l[PROD_W-1] ? MAG_W'(-r_c_prod_l) : MAG_W'(r_c_prod_l);
        mag_r  = r_c_prod_r[PROD_W-1] ? MAG_W'(-r_c_prod_r) : MAG_W'(r_c_prod_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pos       <= '0;
            r_timer     <= '0;
            r_b_valid   <= 1'b0;
            r_b_play    <= 1'b0;
            r_b_emit    <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_pos   <= n_pos;
            r_timer <= n_timer;
            if (advance) begin
                r_b_valid   <= tick_c;
                r_b_play    <= tick_c && play_c;
                r_b_emit    <= tick_c && emit_c;
                r_c_valid   <= r_b_valid;
                r_d_valid   <= r_c_valid;
                r_out_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_c_play   <= r_b_play;
            r_c_prod_l <= PROD_W'(data_l) * vol_s;
            r_c_prod_r <= PROD_W'(data_r) * vol_s;
            r_d_play   <= r_c_play;
            r_d_neg_l  <= r_c_prod_l[PROD_W-1];
            r_d_neg_r  <= r_c_prod_r[PROD_W-1];
            r_d_mk_l   <= MK_W'(mag_l) * MK_W'(RECIP_K);
            r_d_mk_r   <= MK_W'(mag_r) * MK_W'(RECIP_K);
            r_out_item.out_left  <= sat_scale(r_d_mk_l, r_d_neg_l);
            r_out_item.out_right <= sat_scale(r_d_mk_r, r_d_neg_r);
            r_out_item.playing   <= r_d_play;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `NRSP_ASSERT_NEXT(a_note_on_restart, take && i_op.kind == OP_NOTE_ON, r_pos == '0 && r_timer == '0, "note-on did not restart playback")
    `NRSP_ASSERT_ALWAYS(a_pos_in_memory, r_pos <= POS_W'(SAMPLE_DEPTH), "play position past sample memory")
    `NRSP_ASSERT_ALWAYS(a_emit_needs_play, !r_b_emit || (r_b_play && r_b_valid), "sample emitted without held tempo note")

endmodule
